>>> rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types, widths and codes for the triangle barycentric setup block.
// ----------------------------------------------------------------------------
package tbs_pkg;

    // widths of the arithmetic chain
    localparam int CW    = 32;   // vertex coordinate, Q16.16
    localparam int EW    = 33;   // edge component
    localparam int PW    = 66;   // edge product
    localparam int NW    = 67;   // normal component and squared edge length
    localparam int GW    = 100;  // gradient numerator component
    localparam int DW    = 133;  // vertex dot gradient numerator
    localparam int GGW   = 132;  // squared normal length
    localparam int LPW   = 98;   // limit times squared edge length
    localparam int MW    = 34;   // narrow multiplier operand
    localparam int BW    = 102;  // wide multiplier operand
    localparam int XW    = 136;  // multiplier product
    localparam int RW    = 180;  // divider remainder
    localparam int QW    = 47;   // quotient bits below saturation
    localparam int OW    = 48;   // result coefficient, Q24.24
    localparam int LANES = 4;    // x, y, z and offset
    localparam int G_SHIFT = 40; // gradient scale to Q24.24
    localparam int D_SHIFT = 24; // offset scale to Q24.24

    localparam logic [CW-1:0] LIMIT_RESET = 32'd4295;
    localparam logic [OW-1:0] COEF_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [OW-1:0] COEF_MIN    = 48'h8000_0000_0000;

    // row codes
    localparam logic [1:0] ROW0     = 2'd0;
    localparam logic [1:0] ROW1     = 2'd1;
    localparam logic [1:0] ROW2     = 2'd2;
    localparam logic [1:0] ROW_LAST = ROW2;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic [1:0]           row_index;
        logic signed [OW-1:0] coef_x;
        logic signed [OW-1:0] coef_y;
        logic signed [OW-1:0] coef_z;
        logic signed [OW-1:0] coef_offset;
        logic                 degenerate;
        logic                 last_row;
    } t_row_out;

    // one row ready for division
    typedef struct packed {
        logic signed [GW-1:0] g_x;
        logic signed [GW-1:0] g_y;
        logic signed [GW-1:0] g_z;
        logic signed [DW-1:0] dot;
        logic [GGW-1:0]       gg;
    } t_row_rec;

    // one whole triangle in the queue
    typedef struct packed {
        t_row_rec [2:0] rows;
        logic           deg;
    } t_tri_rec;

    typedef struct packed {
        logic [1:0] row_index;
        logic       degenerate;
        logic       last_row;
    } t_tag;

endpackage

>>> rtl/tbs_mul.sv
// ----------------------------------------------------------------------------
// tbs_mul
// Two-stage signed multiplier, 34 x 102 bits, built from three partial products
// of 34-bit slices of the wide operand, registered before they are summed.
// ----------------------------------------------------------------------------
module tbs_mul (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [tbs_pkg::MW-1:0]    i_a,
    input  logic signed [tbs_pkg::BW-1:0]    i_b,
    output logic signed [tbs_pkg::XW-1:0]    o_p
);

    logic signed [2*tbs_pkg::MW:0]   r_pp0;
    logic signed [2*tbs_pkg::MW:0]   r_pp1;
    logic signed [2*tbs_pkg::MW-1:0] r_pp2;
    logic signed [tbs_pkg::XW-1:0]   r_p;

    // form the partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp0 <= i_a * $signed({1'b0, i_b[tbs_pkg::MW-1:0]});
            r_pp1 <= i_a * $signed({1'b0, i_b[2*tbs_pkg::MW-1:tbs_pkg::MW]});
            r_pp2 <= i_a * $signed(i_b[tbs_pkg::BW-1:2*tbs_pkg::MW]);
        end
    end

    // add them at their weights
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= tbs_pkg::XW'(r_pp0)
                 + (tbs_pkg::XW'(r_pp1) <<< tbs_pkg::MW)
                 + (tbs_pkg::XW'(r_pp2) <<< (2*tbs_pkg::MW));
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/tbs_front.sv
// ----------------------------------------------------------------------------
// tbs_front
// Accepts triangles, steps through the three rotated rows one per cycle while
// the queue has room, works out edges, normal, gradient numerator and squared
// lengths, flags a degenerate triangle and hands whole triangles to the queue.
// ----------------------------------------------------------------------------
module tbs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [tbs_pkg::CW-1:0]    i_limit,
    input  logic                      i_valid,
    input  tbs_pkg::t_tri_in          i_tri,
    output logic                      o_ready,
    input  logic                      i_full,
    output logic                      o_push,
    output tbs_pkg::t_tri_rec         o_rec
);

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    logic en;

    // row sequencer
    logic              r_seq_vld;
    logic [1:0]        r_row;
    tbs_pkg::t_tri_in  r_tri;

    logic signed [tbs_pkg::CW-1:0] s_v  [3][3];
    logic signed [tbs_pkg::CW-1:0] s_p1 [3];
    logic signed [tbs_pkg::CW-1:0] s_p2 [3];
    logic signed [tbs_pkg::CW-1:0] s_p3 [3];

    // pipeline registers
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld, r9_vld;
    logic [1:0] r1_row, r2_row, r3_row, r4_row, r5_row, r6_row, r7_row, r8_row, r9_row;

    logic signed [tbs_pkg::EW-1:0] r1_e  [3];
    logic signed [tbs_pkg::EW-1:0] r1_f  [3];
    logic signed [tbs_pkg::CW-1:0] r1_p2 [3];

    logic signed [tbs_pkg::PW-1:0] r2_ff [3];
    logic signed [tbs_pkg::PW-1:0] r2_ct [3];
    logic signed [tbs_pkg::PW-1:0] r2_cu [3];
    logic signed [tbs_pkg::EW-1:0] r2_f  [3];
    logic signed [tbs_pkg::CW-1:0] r2_p2 [3];

    logic [tbs_pkg::NW-1:0]        r3_pp;
    logic signed [tbs_pkg::NW-1:0] r3_n  [3];
    logic signed [tbs_pkg::EW-1:0] r3_f  [3];
    logic signed [tbs_pkg::CW-1:0] r3_p2 [3];

    logic                          r4_ppdeg, r5_ppdeg, r6_ppdeg;
    logic signed [tbs_pkg::CW-1:0] r4_p2 [3];
    logic signed [tbs_pkg::CW-1:0] r5_p2 [3];
    logic signed [tbs_pkg::CW-1:0] r6_p2 [3];

    logic [tbs_pkg::GGW-1:0]       r6_gg, r7_gg, r8_gg, r9_gg;
    logic [tbs_pkg::LPW-1:0]       r6_lp;
    logic signed [tbs_pkg::GW-1:0] r6_g [3];
    logic signed [tbs_pkg::GW-1:0] r7_g [3];
    logic signed [tbs_pkg::GW-1:0] r8_g [3];
    logic signed [tbs_pkg::GW-1:0] r9_g [3];
    logic                          r7_deg, r8_deg, r9_deg;
    logic signed [tbs_pkg::DW-1:0] r9_dot;

    // multiplier outputs
    logic signed [tbs_pkg::XW-1:0] s_nh [3];
    logic signed [tbs_pkg::XW-1:0] s_nl [3];
    logic signed [tbs_pkg::XW-1:0] s_gp [3];
    logic signed [tbs_pkg::XW-1:0] s_gm [3];
    logic signed [tbs_pkg::XW-1:0] s_vg [3];
    logic signed [tbs_pkg::XW-1:0] s_lp;
    logic signed [tbs_pkg::XW-1:0] s_gg;
    logic signed [tbs_pkg::XW-1:0] s_dot;

    // triangle assembly
    tbs_pkg::t_row_rec r_abuf0, r_abuf1, s_cur;
    logic              r_adeg;

    assign en      = !i_full;
    assign o_ready = en && (!r_seq_vld || r_row == tbs_pkg::ROW_LAST);

    // step the row counter, take a new triangle on the last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_vld <= 1'b0;
            r_row     <= tbs_pkg::ROW0;
        end else if (en) begin
            if (i_valid && o_ready) begin
                r_seq_vld <= 1'b1;
                r_row     <= tbs_pkg::ROW0;
            end else if (r_seq_vld) begin
                if (r_row == tbs_pkg::ROW_LAST) begin
                    r_seq_vld <= 1'b0;
                end else begin
                    r_row <= r_row + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tri <= i_tri;
        end
    end

    // rotate the vertices for the current row
    always_comb begin
        s_v[0][0] = r_tri.a_x; s_v[0][1] = r_tri.a_y; s_v[0][2] = r_tri.a_z;
        s_v[1][0] = r_tri.b_x; s_v[1][1] = r_tri.b_y; s_v[1][2] = r_tri.b_z;
        s_v[2][0] = r_tri.c_x; s_v[2][1] = r_tri.c_y; s_v[2][2] = r_tri.c_z;
        case (r_row)
            tbs_pkg::ROW1: begin
                s_p1 = s_v[1]; s_p2 = s_v[2]; s_p3 = s_v[0];
            end
            tbs_pkg::ROW2: begin
                s_p1 = s_v[2]; s_p2 = s_v[0]; s_p3 = s_v[1];
            end
            default: begin
                s_p1 = s_v[0]; s_p2 = s_v[1]; s_p3 = s_v[2];
            end
        endcase
    end

    // advance the valid and row tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0; r2_vld <= 1'b0; r3_vld <= 1'b0;
            r4_vld <= 1'b0; r5_vld <= 1'b0; r6_vld <= 1'b0;
            r7_vld <= 1'b0; r8_vld <= 1'b0; r9_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r_seq_vld; r2_vld <= r1_vld; r3_vld <= r2_vld;
            r4_vld <= r3_vld;    r5_vld <= r4_vld; r6_vld <= r5_vld;
            r7_vld <= r6_vld;    r8_vld <= r7_vld; r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_row <= r_row;  r2_row <= r1_row; r3_row <= r2_row;
            r4_row <= r3_row; r5_row <= r4_row; r6_row <= r5_row;
            r7_row <= r6_row; r8_row <= r7_row; r9_row <= r8_row;
        end
    end

    // edges, edge products, normal and squared edge length
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_e[i]  <= tbs_pkg::EW'(s_p1[i]) - tbs_pkg::EW'(s_p2[i]);
                r1_f[i]  <= tbs_pkg::EW'(s_p3[i]) - tbs_pkg::EW'(s_p2[i]);
                r1_p2[i] <= s_p2[i];

                r2_ff[i] <= r1_f[i] * r1_f[i];
                r2_ct[i] <= r1_e[NXT[i]] * r1_f[PRV[i]];
                r2_cu[i] <= r1_e[PRV[i]] * r1_f[NXT[i]];
                r2_f[i]  <= r1_f[i];
                r2_p2[i] <= r1_p2[i];

                r3_n[i]  <= tbs_pkg::NW'(r2_ct[i]) - tbs_pkg::NW'(r2_cu[i]);
                r3_f[i]  <= r2_f[i];
                r3_p2[i] <= r2_p2[i];

                r4_p2[i] <= r3_p2[i];
                r5_p2[i] <= r4_p2[i];
                r6_p2[i] <= r5_p2[i];
            end
            r3_pp <= tbs_pkg::NW'($unsigned(r2_ff[0])) + tbs_pkg::NW'($unsigned(r2_ff[1]))
                   + tbs_pkg::NW'($unsigned(r2_ff[2]));
            r4_ppdeg <= r3_pp <= tbs_pkg::NW'(i_limit);
            r5_ppdeg <= r4_ppdeg;
            r6_ppdeg <= r5_ppdeg;
        end
    end

    // wide products: squared normal, gradient numerator, limit times length, vertex dot gradient
    for (genvar gi = 0; gi < 3; gi++) begin : g_mul
        tbs_mul u_nh (
            .i_clk (i_clk), .i_en (en),
            .i_a   (r3_n[gi][tbs_pkg::NW-1:tbs_pkg::EW]),
            .i_b   (tbs_pkg::BW'(r3_n[gi])),
            .o_p   (s_nh[gi])
        );
        tbs_mul u_nl (
            .i_clk (i_clk), .i_en (en),
            .i_a   ($signed({1'b0, r3_n[gi][tbs_pkg::EW-1:0]})),
            .i_b   (tbs_pkg::BW'(r3_n[gi])),
            .o_p   (s_nl[gi])
        );
        tbs_mul u_gp (
            .i_clk (i_clk), .i_en (en),
            .i_a   (tbs_pkg::MW'(r3_f[NXT[gi]])),
            .i_b   (tbs_pkg::BW'(r3_n[PRV[gi]])),
            .o_p   (s_gp[gi])
        );
        tbs_mul u_gm (
            .i_clk (i_clk), .i_en (en),
            .i_a   (tbs_pkg::MW'(r3_f[PRV[gi]])),
            .i_b   (tbs_pkg::BW'(r3_n[NXT[gi]])),
            .o_p   (s_gm[gi])
        );
        tbs_mul u_vg (
            .i_clk (i_clk), .i_en (en),
            .i_a   (tbs_pkg::MW'(r6_p2[gi])),
            .i_b   (tbs_pkg::BW'(r6_g[gi])),
            .o_p   (s_vg[gi])
        );
    end

    tbs_mul u_lp (
        .i_clk (i_clk), .i_en (en),
        .i_a   ($signed({2'b00, i_limit})),
        .i_b   ($signed({(tbs_pkg::BW-tbs_pkg::NW)'(0), r3_pp})),
        .o_p   (s_lp)
    );

    // sum the squared normal and the vertex dot products
    always_comb begin
        s_gg  = '0;
        s_dot = '0;
        for (int i = 0; i < 3; i++) begin
            s_gg  = s_gg + (s_nh[i] <<< tbs_pkg::EW) + s_nl[i];
            s_dot = s_dot + s_vg[i];
        end
    end

    // gradient, squared normal, degenerate test, offset numerator
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_g[i] <= tbs_pkg::GW'(s_gp[i] - s_gm[i]);
                r7_g[i] <= r6_g[i];
                r8_g[i] <= r7_g[i];
                r9_g[i] <= r8_g[i];
            end
            r6_gg  <= tbs_pkg::GGW'(s_gg);
            r6_lp  <= s_lp[tbs_pkg::LPW-1:0];
            r7_gg  <= r6_gg;
            r8_gg  <= r7_gg;
            r9_gg  <= r8_gg;
            r7_deg <= r6_ppdeg || (r6_gg <= tbs_pkg::GGW'(r6_lp));
            r8_deg <= r7_deg;
            r9_deg <= r8_deg;
            r9_dot <= tbs_pkg::DW'(s_dot);
        end
    end

    // collect rows into one triangle record
    always_comb begin
        s_cur.g_x = r9_g[0];
        s_cur.g_y = r9_g[1];
        s_cur.g_z = r9_g[2];
        s_cur.dot = r9_dot;
        s_cur.gg  = r9_gg;
        o_rec.rows[0] = r_abuf0;
        o_rec.rows[1] = r_abuf1;
        o_rec.rows[2] = s_cur;
        o_rec.deg     = r_adeg | r9_deg;
    end

    assign o_push = en && r9_vld && r9_row == tbs_pkg::ROW_LAST;

    always_ff @(posedge i_clk) begin
        if (en && r9_vld) begin
            case (r9_row)
                tbs_pkg::ROW0: r_abuf0 <= s_cur;
                tbs_pkg::ROW1: r_abuf1 <= s_cur;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adeg <= 1'b0;
        end else if (en && r9_vld) begin
            r_adeg <= (r9_row == tbs_pkg::ROW_LAST) ? 1'b0 : (r_adeg | r9_deg);
        end
    end

endmodule

>>> rtl/tbs_queue.sv
// ----------------------------------------------------------------------------
// tbs_queue
// Two-entry triangle queue between the setup front end and the divider.
// ----------------------------------------------------------------------------
module tbs_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tbs_pkg::t_tri_rec  i_rec,
    output logic               o_full,
    output logic               o_valid,
    output tbs_pkg::t_tri_rec  o_rec,
    input  logic               i_pop
);

    tbs_pkg::t_tri_rec r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_rec   = r_mem[r_rp];

    // store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    // move the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> rtl/tbs_back.sv
// ----------------------------------------------------------------------------
// tbs_back
// Issues one row per cycle from the queue, while the output is not stalled,
// into four restoring divider lanes (x, y, z, offset), one quotient bit per
// stage, and saturates the result into the output register.
// ----------------------------------------------------------------------------
module tbs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  tbs_pkg::t_tri_rec  i_q_rec,
    output logic               o_pop,
    output logic               o_valid,
    output tbs_pkg::t_row_out  o_row,
    input  logic               i_ready
);

    localparam int L = tbs_pkg::LANES;
    localparam int S = tbs_pkg::QW;

    logic              en, issue;
    logic [1:0]        r_brow;
    tbs_pkg::t_row_rec s_row;
    tbs_pkg::t_tag     s_tag;

    logic [tbs_pkg::RW-1:0] s_mag [L];
    logic                   s_neg [L];
    logic [tbs_pkg::GW-1:0] s_absg [3];
    logic signed [tbs_pkg::GW-1:0] s_g [3];
    logic [tbs_pkg::DW-1:0] s_absd;

    // divider stages
    logic                    r_dv  [S];
    tbs_pkg::t_tag           r_tag [S];
    logic [tbs_pkg::GGW-1:0] r_gg  [S];
    logic [tbs_pkg::RW-1:0]  r_rem [S][L];
    logic [tbs_pkg::QW-1:0]  r_q   [S][L];
    logic                    r_neg [S][L];
    logic                    r_sat [S][L];

    // output
    logic                   r_ov;
    tbs_pkg::t_row_out      r_out;
    logic [tbs_pkg::RW:0]   s_t0 [L];
    logic [tbs_pkg::QW-1:0] s_qf [L];
    logic [tbs_pkg::OW-1:0] s_coef [L];

    assign en    = !r_ov || i_ready;
    assign issue = en && i_q_valid;
    assign o_pop = issue && (i_q_rec.deg || r_brow == tbs_pkg::ROW_LAST);

    // walk the rows of the head triangle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brow <= tbs_pkg::ROW0;
        end else if (issue) begin
            r_brow <= o_pop ? tbs_pkg::ROW0 : r_brow + 2'd1;
        end
    end

    always_comb begin
        case (r_brow)
            tbs_pkg::ROW1: s_row = i_q_rec.rows[1];
            tbs_pkg::ROW2: s_row = i_q_rec.rows[2];
            default:       s_row = i_q_rec.rows[0];
        endcase
        s_tag.row_index  = i_q_rec.deg ? tbs_pkg::ROW0 : r_brow;
        s_tag.degenerate = i_q_rec.deg;
        s_tag.last_row   = i_q_rec.deg || r_brow == tbs_pkg::ROW_LAST;
    end

    // split numerators into sign and scaled magnitude
    always_comb begin
        s_g[0] = s_row.g_x;
        s_g[1] = s_row.g_y;
        s_g[2] = s_row.g_z;
        for (int i = 0; i < 3; i++) begin
            s_absg[i] = s_g[i][tbs_pkg::GW-1] ? $unsigned(-s_g[i]) : $unsigned(s_g[i]);
            s_neg[i]  = s_g[i][tbs_pkg::GW-1];
            s_mag[i]  = tbs_pkg::RW'(s_absg[i]) << tbs_pkg::G_SHIFT;
        end
        s_absd   = s_row.dot[tbs_pkg::DW-1] ? $unsigned(-s_row.dot) : $unsigned(s_row.dot);
        s_neg[3] = !s_row.dot[tbs_pkg::DW-1] && (s_row.dot != '0);
        s_mag[3] = tbs_pkg::RW'(s_absd) << tbs_pkg::D_SHIFT;
    end

    // first stage: load and test for saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= s_tag;
            r_gg[0]  <= s_row.gg;
            for (int l = 0; l < L; l++) begin
                r_rem[0][l] <= s_mag[l];
                r_neg[0][l] <= s_neg[l];
                r_sat[0][l] <= s_mag[l] >= (tbs_pkg::RW'(s_row.gg) << tbs_pkg::QW);
                r_q[0][l]   <= '0;
            end
        end
    end

    // one quotient bit per stage
    for (genvar gs = 1; gs < S; gs++) begin : g_stage
        localparam int K = tbs_pkg::QW - gs;
        logic [tbs_pkg::RW:0] s_t [L];

        always_comb begin
            for (int l = 0; l < L; l++) begin
                s_t[l] = {1'b0, r_rem[gs-1][l]}
                       - {1'b0, tbs_pkg::RW'(r_gg[gs-1]) << K};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gs] <= 1'b0;
            end else if (en) begin
                r_dv[gs] <= r_dv[gs-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_tag[gs] <= r_tag[gs-1];
                r_gg[gs]  <= r_gg[gs-1];
                for (int l = 0; l < L; l++) begin
                    r_rem[gs][l] <= s_t[l][tbs_pkg::RW] ? r_rem[gs-1][l]
                                                        : s_t[l][tbs_pkg::RW-1:0];
                    r_q[gs][l]   <= r_q[gs-1][l]
                                  | ({{(tbs_pkg::QW-1){1'b0}}, ~s_t[l][tbs_pkg::RW]} << K);
                    r_neg[gs][l] <= r_neg[gs-1][l];
                    r_sat[gs][l] <= r_sat[gs-1][l];
                end
            end
        end
    end

    // last quotient bit, sign and saturation
    always_comb begin
        for (int l = 0; l < L; l++) begin
            s_t0[l] = {1'b0, r_rem[S-1][l]} - {1'b0, tbs_pkg::RW'(r_gg[S-1])};
            s_qf[l] = r_q[S-1][l] | {{(tbs_pkg::QW-1){1'b0}}, ~s_t0[l][tbs_pkg::RW]};
            if (r_tag[S-1].degenerate) begin
                s_coef[l] = '0;
            end else if (r_sat[S-1][l]) begin
                s_coef[l] = r_neg[S-1][l] ? tbs_pkg::COEF_MIN : tbs_pkg::COEF_MAX;
            end else if (r_neg[S-1][l]) begin
                s_coef[l] = -tbs_pkg::OW'(s_qf[l]);
            end else begin
                s_coef[l] = tbs_pkg::OW'(s_qf[l]);
            end
        end
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[S-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.row_index   <= r_tag[S-1].row_index;
            r_out.coef_x      <= s_coef[0];
            r_out.coef_y      <= s_coef[1];
            r_out.coef_z      <= s_coef[2];
            r_out.coef_offset <= s_coef[3];
            r_out.degenerate  <= r_tag[S-1].degenerate;
            r_out.last_row    <= r_tag[S-1].last_row;
        end
    end

    assign o_valid = r_ov;
    assign o_row   = r_out;

endmodule

>>> rtl/triangle_barycentric_setup_top.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_setup_top
// Barycentric plane setup: one triangle in, three Q24.24 plane rows out, or
// a single flagged word for a degenerate triangle.
// ----------------------------------------------------------------------------
// The front end takes a new triangle as it issues the last row of the one
// before and walks the three rotated rows through its multipliers one row
// per cycle while the queue has room; the result port gives one row word per
// cycle while not stalled. A degenerate triangle still passes all three rows
// through the front end but gives only one output word. From the accepting
// edge to the first result word lie nine front-end stages after the input
// register, a wait for the third row (the queue takes whole triangles), the
// queue write, 47 divider stages (one quotient bit each, four lanes side by
// side) and the output register. Output back-pressure stalls the divider;
// the queue lets the front end accept until it holds two finished triangles.
// ----------------------------------------------------------------------------
module triangle_barycentric_setup_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tbs_pkg::CW-1:0]    i_cfg_data,
    input  logic                      i_valid,
    input  tbs_pkg::t_tri_in          i_tri,
    output logic                      o_ready,
    output logic                      o_valid,
    output tbs_pkg::t_row_out         o_row,
    input  logic                      i_ready
);

    logic [tbs_pkg::CW-1:0] r_limit;
    logic                   s_push, s_full, s_qvalid, s_pop;
    tbs_pkg::t_tri_rec      s_prec, s_qrec;

    // degenerate limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= tbs_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    tbs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_limit),
        .i_valid (i_valid),
        .i_tri   (i_tri),
        .o_ready (o_ready),
        .i_full  (s_full),
        .o_push  (s_push),
        .o_rec   (s_prec)
    );

    tbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_rec   (s_prec),
        .o_full  (s_full),
        .o_valid (s_qvalid),
        .o_rec   (s_qrec),
        .i_pop   (s_pop)
    );

    tbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (s_qvalid),
        .i_q_rec   (s_qrec),
        .o_pop     (s_pop),
        .o_valid   (o_valid),
        .o_row     (o_row),
        .i_ready   (i_ready)
    );

    // never push into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> !s_full)
        else $error("triangle pushed into a full queue");

    // never pop an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> s_qvalid)
        else $error("triangle popped from an empty queue");

    // a degenerate word is alone and carries no coefficients
    a_deg_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_row.degenerate) |->
            (o_row.last_row && o_row.row_index == tbs_pkg::ROW0
             && o_row.coef_x == '0 && o_row.coef_y == '0
             && o_row.coef_z == '0 && o_row.coef_offset == '0))
        else $error("degenerate word malformed");

    // a held result stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_row)))
        else $error("result word changed while stalled");

endmodule

>>> sim/triangle_barycentric_setup_top_tb.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_setup_top_tb
// Self-checking bench for the barycentric plane setup block. Triangles are
// pushed through a valid/ready port with random gaps. Each accepted word is
// turned into its expected plane rows by exact wide integer arithmetic. Every
// output word is checked, field by field, against the oldest row still
// expected. The phases step the degenerate threshold through its reset value,
// zero, full scale and random values.
// ----------------------------------------------------------------------------
module triangle_barycentric_setup_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] t_wide;

    // ------------------------------------------------------------------------
    // plane row predictor and result store
    // ------------------------------------------------------------------------
    class plane_row_board;
        tbs_pkg::t_row_out rows_due[$];
        logic [31:0]       deg_limit;
        int                n_bad;

        function new();
            deg_limit = tbs_pkg::LIMIT_RESET;
            n_bad     = 0;
        endfunction

        // quotient truncated toward zero, then clamped to 48 bits
        function logic [tbs_pkg::OW-1:0] div_clamp(t_wide num, t_wide den);
            t_wide mag;
            t_wide quo;
            logic  neg;
            neg = num < 0;
            mag = neg ? -num : num;
            quo = mag / den;
            if (quo >= (t_wide'(1) <<< 47)) begin
                return neg ? tbs_pkg::COEF_MIN : tbs_pkg::COEF_MAX;
            end
            return neg ? tbs_pkg::OW'(-quo) : tbs_pkg::OW'(quo);
        endfunction

        // one rotated row; returns 1 when the row is too thin
        function bit plane_row(t_wide p1[3], t_wide p2[3], t_wide p3[3],
                               output logic [tbs_pkg::OW-1:0] coef[4]);
            t_wide e[3], f[3], n[3], g[3];
            t_wide ff, nn, dp, lim;
            lim = t_wide'({1'b0, deg_limit});
            for (int i = 0; i < 3; i++) begin
                e[i] = p1[i] - p2[i];
                f[i] = p3[i] - p2[i];
            end
            ff = f[0]*f[0] + f[1]*f[1] + f[2]*f[2];
            if (ff <= lim) return 1;
            for (int i = 0; i < 3; i++) begin
                n[i] = e[(i+1)%3]*f[(i+2)%3] - e[(i+2)%3]*f[(i+1)%3];
            end
            nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
            if (nn <= lim * ff) return 1;
            for (int i = 0; i < 3; i++) begin
                g[i] = f[(i+1)%3]*n[(i+2)%3] - f[(i+2)%3]*n[(i+1)%3];
                coef[i] = div_clamp(g[i] <<< tbs_pkg::G_SHIFT, nn);
            end
            dp = p2[0]*g[0] + p2[1]*g[1] + p2[2]*g[2];
            coef[3] = div_clamp((-dp) <<< tbs_pkg::D_SHIFT, nn);
            return 0;
        endfunction

        // note an accepted triangle and queue its rows
        function void note_tri(tbs_pkg::t_tri_in t);
            t_wide                   v[3][3];
            logic [tbs_pkg::OW-1:0]  c[3][4];
            bit                      thin;
            tbs_pkg::t_row_out       r;
            v[0][0] = t.a_x; v[0][1] = t.a_y; v[0][2] = t.a_z;
            v[1][0] = t.b_x; v[1][1] = t.b_y; v[1][2] = t.b_z;
            v[2][0] = t.c_x; v[2][1] = t.c_y; v[2][2] = t.c_z;
            thin = 0;
            for (int j = 0; j < 3 && !thin; j++) begin
                thin = plane_row(v[j], v[(j+1)%3], v[(j+2)%3], c[j]);
            end
            if (thin) begin
                r = '0;
                r.row_index  = tbs_pkg::ROW0;
                r.degenerate = 1'b1;
                r.last_row   = 1'b1;
                rows_due.push_back(r);
                return;
            end
            for (int j = 0; j < 3; j++) begin
                r.row_index   = 2'(j);
                r.coef_x      = c[j][0];
                r.coef_y      = c[j][1];
                r.coef_z      = c[j][2];
                r.coef_offset = c[j][3];
                r.degenerate  = 1'b0;
                r.last_row    = (2'(j) == tbs_pkg::ROW_LAST);
                rows_due.push_back(r);
            end
        endfunction

        // compare a delivered row with the oldest one due
        function void check_row(tbs_pkg::t_row_out got);
            tbs_pkg::t_row_out want;
            if (rows_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected row word %p", got);
                return;
            end
            want = rows_due.pop_front();
            if (got.row_index !== want.row_index || got.coef_x !== want.coef_x ||
                got.coef_y !== want.coef_y || got.coef_z !== want.coef_z ||
                got.coef_offset !== want.coef_offset ||
                got.degenerate !== want.degenerate || got.last_row !== want.last_row)
            begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("row mismatch: expected %p", want);
                    $display("               actual %p", got);
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [tbs_pkg::CW-1:0] i_cfg_data;
    logic                   i_valid;
    tbs_pkg::t_tri_in       i_tri;
    logic                   o_ready;
    logic                   o_valid;
    tbs_pkg::t_row_out      o_row;
    logic                   i_ready;

    plane_row_board board;
    int gap_pct;
    int stall_pct;

    triangle_barycentric_setup_top u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .i_tri     (i_tri),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .o_row     (o_row),
        .i_ready   (i_ready)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // watch both ports on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_tri(i_tri);
            if (o_valid && i_ready) board.check_row(o_row);
        end
    end

    // stall the result port at random
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop
    initial begin
        #20ms;
        $display("FAIL triangle_barycentric_setup_top");
        $finish;
    end

    // offer one triangle word and hold it until taken
    task automatic send_tri(tbs_pkg::t_tri_in t);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_tri   <= t;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // drain all expected rows, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        while (board.rows_due.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [tbs_pkg::CW-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        board.deg_limit = v;
    endtask

    function automatic tbs_pkg::t_tri_in mk_tri(int ax, int ay, int az, int bx, int by,
                                                int bz, int cx, int cy, int cz);
        tbs_pkg::t_tri_in t;
        t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz;
        t.c_x = cx; t.c_y = cy; t.c_z = cz;
        return t;
    endfunction

    // coordinate of a chosen spread
    function automatic int pick_coord(int spread);
        case (spread)
            0:       return $urandom;
            1:       return int'($urandom_range(2097152)) - 1048576;
            default: return int'($urandom_range(400)) - 200;
        endcase
    endfunction

    // random triangle: mostly genuine, some collinear or far-off ones
    function automatic tbs_pkg::t_tri_in rand_tri();
        tbs_pkg::t_tri_in t;
        int      kind, sp, k;
        int      base[3];
        kind = $urandom_range(99);
        sp   = $urandom_range(2);
        t = mk_tri(pick_coord(sp), pick_coord(sp), pick_coord(sp),
                   pick_coord(sp), pick_coord(sp), pick_coord(sp),
                   pick_coord(sp), pick_coord(sp), pick_coord(sp));
        if (kind < 12) begin
            // collinear: c on the line through a and b
            k = int'($urandom_range(4)) - 2;
            t.c_x = t.a_x + k * (t.b_x - t.a_x);
            t.c_y = t.a_y + k * (t.b_y - t.a_y);
            t.c_z = t.a_z + k * (t.b_z - t.a_z);
        end else if (kind < 18) begin
            t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
        end else if (kind < 40) begin
            // small triangle far from the origin
            for (int i = 0; i < 3; i++) base[i] = $urandom;
            t = mk_tri(base[0] + pick_coord(2), base[1] + pick_coord(2),
                       base[2] + pick_coord(2), base[0] + pick_coord(2),
                       base[1] + pick_coord(2), base[2] + pick_coord(2),
                       base[0] + pick_coord(2), base[1] + pick_coord(2),
                       base[2] + pick_coord(2));
        end
        return t;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) send_tri(rand_tri());
    endtask

    initial begin
        board      = new();
        gap_pct    = 0;
        stall_pct  = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_tri      = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset threshold, no idling
        send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tri(mk_tri(65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
        send_tri(mk_tri(0, 0, 0, 65, 0, 0, 0, 65, 0));
        send_tri(mk_tri(0, 0, 0, 66, 0, 0, 0, 66, 0));
        send_tri(mk_tri(0, 0, 0, 1000, 0, 0, 2000, 0, 0));
        send_tri(mk_tri(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7FFFFFFF, 32'h80000000, 0));
        send_tri(mk_tri(32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 0,
                        32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF));
        send_tri(mk_tri(32'h7FFFFF00, 32'h7FFFFF00, 32'h7FFFFF00,
                        32'h7FFFFF64, 32'h7FFFFF00, 32'h7FFFFF00,
                        32'h7FFFFF00, 32'h7FFFFF64, 32'h7FFFFF00));
        send_tri(mk_tri(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000064, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000064));
        send_tri(mk_tri(0, 0, 0, 1000000, 1, 0, 2000000, 3, 0));
        send_tri(mk_tri(-65536, 131072, 7, 300000, -5000, 99, 12, 12, -400000));
        run_random(22);

        // threshold zero, sender idles
        drain();
        write_limit('0);
        gap_pct = 68;
        send_tri(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_tri(mk_tri(5, 5, 5, 5, 5, 5, 9, 9, 9));
        send_tri(mk_tri(0, 0, 0, 1000000, 1, 0, 2000000, 3, 0));
        run_random(25);

        // full-scale threshold, receiver stalls
        drain();
        write_limit(32'hFFFFFFFF);
        gap_pct   = 0;
        stall_pct = 68;
        send_tri(mk_tri(32'h7FFFFFFF, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0,
                        0, 32'h80000000, 32'h7FFFFFFF));
        run_random(25);

        // random threshold, light idling on both sides
        drain();
        write_limit($urandom_range(65535));
        gap_pct   = 8;
        stall_pct = 8;
        run_random(20);
        drain();
        write_limit($urandom);
        run_random(15);

        drain();
        if (board.n_bad == 0 && board.rows_due.size() == 0) begin
            $display("PASS triangle_barycentric_setup_top");
        end else begin
            $display("FAIL triangle_barycentric_setup_top");
        end
        $finish;
    end

endmodule
